// File: design/mrc_pkg.sv
// Shared types, constants and the CRC byte update for the Modbus RTU response checker.
package mrc_pkg;

  localparam logic [6:0]  MaxRegisters = 7'd125;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [7:0]  FuncRead     = 8'h03;
  localparam logic [7:0]  FuncWrite    = 8'h06;
  localparam logic [7:0]  FuncExcept   = 8'h83;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam int          CfgIndexW     = 3;
  localparam int          CfgDataW      = 16;
  localparam logic [2:0]  CfgSlaveId    = 3'd0;
  localparam logic [2:0]  CfgAckMode    = 3'd1;
  localparam logic [2:0]  CfgRegCount   = 3'd2;
  localparam logic [2:0]  CfgEchoAddr   = 3'd3;
  localparam logic [2:0]  CfgEchoValue  = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CRC       = 3'd1,
    ST_ID        = 3'd2,
    ST_EXCEPTION = 3'd3,
    ST_FUNCTION  = 3'd4,
    ST_COUNT     = 3'd5,
    ST_ECHO      = 3'd6
  } status_t;

  // Role of a byte within the frame, decided when the byte is accepted.
  typedef enum logic [3:0] {
    KIND_FINAL,
    KIND_CRC_LO,
    KIND_ID,
    KIND_FUNC,
    KIND_ADDR_HI,
    KIND_ADDR_LO,
    KIND_VALUE_HI,
    KIND_VALUE_LO,
    KIND_COUNT,
    KIND_DATA_HI,
    KIND_DATA_LO,
    KIND_CRC_ONLY
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    kind_t      kind;
    logic       restart;
    logic [6:0] word_index;
  } item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/mrc_front.sv
// Front end: tracks the byte position and tags each accepted byte with its role.
module mrc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    rx_byte,
  input  logic          frame_start,
  input  logic          ack_mode,
  input  logic [6:0]    count,
  input  logic          queue_full,
  output logic          push,
  output mrc_pkg::item_t item
);
  import mrc_pkg::*;

  logic [7:0] byte_position;
  logic [6:0] word_counter;
  logic [7:0] idx;
  logic [6:0] wc;
  logic [8:0] frame_len;
  logic [8:0] idx_plus1;
  logic [8:0] idx_plus2;
  kind_t      kind;

  assign push      = in_valid && !queue_full;
  assign idx       = frame_start ? 8'd0 : byte_position;
  assign wc        = frame_start ? 7'd0 : word_counter;
  assign frame_len = ack_mode ? 9'd8 : (9'd5 + {1'b0, count, 1'b0});
  assign idx_plus1 = {1'b0, idx} + 9'd1;
  assign idx_plus2 = {1'b0, idx} + 9'd2;

  always_comb begin
    if (idx_plus1 >= frame_len) begin
      kind = KIND_FINAL;
    end else if (idx_plus2 == frame_len) begin
      kind = KIND_CRC_LO;
    end else if (idx == 8'd0) begin
      kind = KIND_ID;
    end else if (idx == 8'd1) begin
      kind = KIND_FUNC;
    end else if (ack_mode) begin
      case (idx)
        8'd2:    kind = KIND_ADDR_HI;
        8'd3:    kind = KIND_ADDR_LO;
        8'd4:    kind = KIND_VALUE_HI;
        8'd5:    kind = KIND_VALUE_LO;
        default: kind = KIND_CRC_ONLY;
      endcase
    end else if (idx == 8'd2) begin
      kind = KIND_COUNT;
    end else if (idx[0]) begin
      kind = KIND_DATA_HI;
    end else begin
      kind = KIND_DATA_LO;
    end
  end

  assign item.rx_byte    = rx_byte;
  assign item.kind       = kind;
  assign item.restart    = frame_start;
  assign item.word_index = wc;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 8'd0;
      word_counter  <= 7'd0;
    end else if (push) begin
      if (kind == KIND_FINAL) begin
        byte_position <= 8'd0;
        word_counter  <= 7'd0;
      end else begin
        byte_position <= idx + 8'd1;
        word_counter  <= (kind == KIND_DATA_LO) ? (wc + 7'd1) : wc;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_final_rewinds: assert property (@(posedge clk) disable iff (rst)
    push && kind == KIND_FINAL |=> byte_position == 8'd0 && word_counter == 7'd0)
    else $error("frame position not rewound after final byte");
`endif

endmodule

// File: design/mrc_queue.sv
// Two-entry queue of tagged bytes between the front and back ends.
module mrc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrc_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output mrc_pkg::item_t head
);
  import mrc_pkg::*;

  item_t                entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> count == QueueCntW'(QueueDepth))
    else $error("queue lost or gained an entry while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");
`endif

endmodule

// File: design/mrc_back.sv
// Back end: CRC, header capture, frame checks and the output register.
module mrc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  mrc_pkg::item_t q_head,
  output logic           pop,
  input  logic [7:0]     slave_id,
  input  logic           ack_mode,
  input  logic [6:0]     count,
  input  logic [15:0]    echo_address,
  input  logic [15:0]    echo_value,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           is_status,
  output logic [15:0]    data_word,
  output logic [6:0]     word_index,
  output logic [2:0]     status
);
  import mrc_pkg::*;

  logic [15:0] running_crc;
  logic [7:0]  received_id;
  logic [7:0]  received_function;
  logic [7:0]  received_count;
  logic [7:0]  pending_high_byte;
  logic [15:0] echo_address_seen;
  logic [15:0] echo_value_seen;
  logic [7:0]  crc_low_byte;

  logic [15:0] crc_base;
  logic [15:0] crc_next;
  status_t     frame_status;

  assign pop      = q_not_empty && (!out_valid || !out_stall);
  assign crc_base = q_head.restart ? CrcInit : running_crc;
  assign crc_next = crc_byte(crc_base, q_head.rx_byte);

  always_comb begin
    if ({q_head.rx_byte, crc_low_byte} != crc_base) begin
      frame_status = ST_CRC;
    end else if (received_id != slave_id) begin
      frame_status = ST_ID;
    end else if (received_function == FuncExcept) begin
      frame_status = ST_EXCEPTION;
    end else if (received_function != (ack_mode ? FuncWrite : FuncRead)) begin
      frame_status = ST_FUNCTION;
    end else if (!ack_mode && received_count != {count, 1'b0}) begin
      frame_status = ST_COUNT;
    end else if (ack_mode && (echo_address_seen != echo_address ||
                              echo_value_seen != echo_value)) begin
      frame_status = ST_ECHO;
    end else begin
      frame_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      running_crc       <= CrcInit;
      received_id       <= 8'd0;
      received_function <= 8'd0;
      received_count    <= 8'd0;
      pending_high_byte <= 8'd0;
      echo_address_seen <= 16'd0;
      echo_value_seen   <= 16'd0;
      crc_low_byte      <= 8'd0;
    end else begin
      if (pop && (q_head.kind == KIND_FINAL || q_head.kind == KIND_DATA_LO)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (q_head.kind == KIND_FINAL || q_head.kind == KIND_CRC_LO) begin
          running_crc <= (q_head.kind == KIND_FINAL) ? CrcInit : crc_base;
        end else begin
          running_crc <= crc_next;
        end
        case (q_head.kind)
          KIND_FINAL: begin
            is_status  <= 1'b1;
            data_word  <= 16'd0;
            word_index <= 7'd0;
            status     <= frame_status;
          end
          KIND_CRC_LO:   crc_low_byte                <= q_head.rx_byte;
          KIND_ID:       received_id                 <= q_head.rx_byte;
          KIND_FUNC:     received_function           <= q_head.rx_byte;
          KIND_ADDR_HI:  echo_address_seen[15:8]     <= q_head.rx_byte;
          KIND_ADDR_LO:  echo_address_seen[7:0]      <= q_head.rx_byte;
          KIND_VALUE_HI: echo_value_seen[15:8]       <= q_head.rx_byte;
          KIND_VALUE_LO: echo_value_seen[7:0]        <= q_head.rx_byte;
          KIND_COUNT:    received_count              <= q_head.rx_byte;
          KIND_DATA_HI:  pending_high_byte           <= q_head.rx_byte;
          KIND_DATA_LO: begin
            is_status  <= 1'b0;
            data_word  <= {pending_high_byte, q_head.rx_byte};
            word_index <= q_head.word_index;
            status     <= ST_OK;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_final_gives_status: assert property (@(posedge clk) disable iff (rst)
    pop && q_head.kind == KIND_FINAL |=> out_valid && is_status)
    else $error("final byte did not produce a status result");
  a_status_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> data_word == 16'd0 && word_index == 7'd0)
    else $error("status result carries data fields");
`endif

endmodule

// File: design/modbus_rtu_response_checker_top.sv
// Top level of the Modbus RTU response checker: configuration registers and the pipeline.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall   rx_byte, frame_start
//   output   out        out_valid / out_stall is_status, data_word, word_index, status
//   config   in         cfg_we                cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the CRC is a byte-wide update in the back end.
// A byte waits in a queue entry before its result is loaded into the output register.
// in_stall rises only when the two-entry queue is full, i.e. after output stalls back up.
// Reset is synchronous and leaves the checker at the start of a frame with the register defaults.
module modbus_rtu_response_checker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          is_status,
  output logic [15:0]                   data_word,
  output logic [6:0]                    word_index,
  output logic [2:0]                    status,
  input  logic                          cfg_we,
  input  logic [mrc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [mrc_pkg::CfgDataW-1:0]  cfg_data
);
  import mrc_pkg::*;

  logic [7:0]  slave_id;
  logic        ack_mode;
  logic [6:0]  register_count;
  logic [15:0] echo_address;
  logic [15:0] echo_value;
  logic [6:0]  count;

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_not_empty;
  item_t push_item;
  item_t q_head;

  assign count    = (register_count > MaxRegisters) ? MaxRegisters : register_count;
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_id       <= 8'd1;
      ack_mode       <= 1'b0;
      register_count <= 7'd1;
      echo_address   <= 16'd0;
      echo_value     <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgSlaveId:   slave_id       <= cfg_data[7:0];
        CfgAckMode:   ack_mode       <= cfg_data[0];
        CfgRegCount:  register_count <= cfg_data[6:0];
        CfgEchoAddr:  echo_address   <= cfg_data;
        CfgEchoValue: echo_value     <= cfg_data;
        default: ;
      endcase
    end
  end

  mrc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .ack_mode    (ack_mode),
    .count       (count),
    .queue_full  (q_full),
    .push        (push),
    .item        (push_item)
  );

  mrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mrc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .pop          (pop),
    .slave_id     (slave_id),
    .ack_mode     (ack_mode),
    .count        (count),
    .echo_address (echo_address),
    .echo_value   (echo_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_status    (is_status),
    .data_word    (data_word),
    .word_index   (word_index),
    .status       (status)
  );

endmodule

// File: test/modbus_rtu_response_checker_top_tb.sv
// Self-checking testbench for the Modbus RTU response checker top level.
module modbus_rtu_response_checker_top_tb;
  import mrc_pkg::*;

  typedef struct packed {
    logic       is_status;
    logic [15:0] data_word;
    logic [6:0] word_index;
    status_t    status;
  } reply_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       starts;
    logic       hold;
  } rx_item_t;

  typedef enum {
    FLAW_NONE, FLAW_CRC, FLAW_ID, FLAW_EXCEPT, FLAW_FUNC,
    FLAW_COUNT, FLAW_ECHO, FLAW_SHORT, FLAW_NOISE
  } flaw_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_status;
  logic [15:0] data_word;
  logic [6:0] word_index;
  logic [2:0] status;
  logic cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  modbus_rtu_response_checker_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_status   (is_status),
    .data_word   (data_word),
    .word_index  (word_index),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Register copies as the block should hold them.
  logic [7:0]  set_slave = 8'd1;
  logic        set_ack = 1'b0;
  logic [6:0]  set_count = 7'd1;
  logic [15:0] set_addr = 16'h0000;
  logic [15:0] set_value = 16'h0000;

  // Frame tracking state of the predictor.
  logic [7:0]  pos_in_frame = 8'd0;
  logic [15:0] crc_acc = CrcInit;
  logic [7:0]  seen_id = 8'd0;
  logic [7:0]  seen_func = 8'd0;
  logic [7:0]  seen_count = 8'd0;
  logic [7:0]  data_high = 8'd0;
  logic [15:0] seen_addr = 16'h0000;
  logic [15:0] seen_value = 16'h0000;
  logic [7:0]  crc_lo_hold = 8'd0;
  logic [6:0]  next_word = 7'd0;

  reply_t   expected_replies[$];
  rx_item_t byte_queue[$];
  logic     drained = 1'b1;
  logic     start_owed = 1'b1;
  int       errors = 0;
  int       burst_left = 4;
  int       gap_left = 0;
  int       stall_tick = 0;
  int       stall_style = 0;

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  task automatic absorb_rx_byte(input logic [7:0] b, input logic fs);
    int unsigned regs, flen, pos;
    reply_t r;
    if (fs) begin
      pos_in_frame = 8'd0;
      crc_acc = CrcInit;
      next_word = 7'd0;
    end
    regs = (set_count > MaxRegisters) ? MaxRegisters : set_count;
    flen = set_ack ? 8 : 5 + 2 * regs;
    pos = pos_in_frame;
    r = '0;
    if (pos + 1 >= flen) begin
      r.is_status = 1'b1;
      if ({b, crc_lo_hold} != crc_acc) r.status = ST_CRC;
      else if (seen_id != set_slave) r.status = ST_ID;
      else if (seen_func == FuncExcept) r.status = ST_EXCEPTION;
      else if (seen_func != (set_ack ? FuncWrite : FuncRead)) r.status = ST_FUNCTION;
      else if (!set_ack && seen_count != 8'(2 * regs)) r.status = ST_COUNT;
      else if (set_ack && (seen_addr != set_addr || seen_value != set_value))
        r.status = ST_ECHO;
      else r.status = ST_OK;
      expected_replies.insert(expected_replies.size(), r);
      pos_in_frame = 8'd0;
      crc_acc = CrcInit;
      next_word = 7'd0;
    end else begin
      pos_in_frame = 8'(pos + 1);
      if (pos + 2 == flen) begin
        crc_lo_hold = b;
      end else begin
        crc_acc = crc16_step(crc_acc, b);
        if (pos == 0) begin
          seen_id = b;
        end else if (pos == 1) begin
          seen_func = b;
        end else if (set_ack) begin
          case (pos)
            2: seen_addr[15:8] = b;
            3: seen_addr[7:0] = b;
            4: seen_value[15:8] = b;
            5: seen_value[7:0] = b;
            default: ;
          endcase
        end else if (pos == 2) begin
          seen_count = b;
        end else if (pos % 2 == 1) begin
          data_high = b;
        end else begin
          // The low byte completes a data word, which goes out at once.
          r.data_word = {data_high, b};
          r.word_index = next_word;
          expected_replies.insert(expected_replies.size(), r);
          next_word = next_word + 7'd1;
        end
      end
    end
  endtask

  task automatic report_failure(input string what, input reply_t want, input reply_t got);
    if (errors < 10)
      $display("%s: expected is_status=%0b word=%h index=%0d status=%0d,",
               what, want.is_status, want.data_word, want.word_index, want.status,
               " got is_status=%0b word=%h index=%0d status=%0d",
               got.is_status, got.data_word, got.word_index, got.status);
    errors++;
  endtask

  // Sender: bursts of random length with random gaps.
  always @(posedge clk) begin : drive_proc
    rx_item_t item_now;
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
      frame_start <= 1'b0;
      burst_left <= 4;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) absorb_rx_byte(rx_byte, frame_start);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (byte_queue[0].hold && (in_valid || !drained)) begin
          // Hold off until every result already owed has been taken.
          in_valid <= 1'b0;
        end else begin
          item_now = byte_queue.pop_front();
          in_valid <= 1'b1;
          rx_byte <= item_now.rx;
          frame_start <= item_now.starts;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 5) == 0) ? 300 : $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver stall pattern: none, rare, random or periodic stalls, with the style picked anew at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_tick <= 0;
      stall_style <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 128 == 127) stall_style <= $urandom_range(0, 3);
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= (stall_tick % 32 >= 24);
      endcase
    end
  end

  // Outputs are stable at the falling edge; a transfer seen here completes
  // at the next rising edge.
  always @(negedge clk) begin : check_proc
    reply_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got.is_status = is_status;
      got.data_word = data_word;
      got.word_index = word_index;
      got.status = status_t'(status);
      if (expected_replies.size() == 0) begin
        report_failure("unexpected result", '0, got);
      end else begin
        want = expected_replies.pop_front();
        if (got !== want) report_failure("result mismatch", want, got);
      end
    end
    drained <= (expected_replies.size() == 0);
  end

  function automatic flaw_t pick_flaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return FLAW_NONE;
    if (r < 53) return FLAW_CRC;
    if (r < 60) return FLAW_ID;
    if (r < 67) return FLAW_EXCEPT;
    if (r < 74) return FLAW_FUNC;
    if (r < 82) return set_ack ? FLAW_ECHO : FLAW_COUNT;
    if (r < 92) return FLAW_SHORT;
    return FLAW_NOISE;
  endfunction

  // Builds one response for the current registers with at most one flaw.
  // fill < 0 gives random data bytes; start_sel 0/1 forces frame_start,
  // 2 chooses it unless a restart is owed.
  task automatic queue_frame(input flaw_t flaw, input int fill, input int start_sel,
                             input logic hold);
    logic [7:0] body[$];
    logic [15:0] crc, addr, value;
    logic [7:0] fn;
    logic first_start;
    int regs, cut, k;
    regs = (set_count > MaxRegisters) ? MaxRegisters : set_count;
    if (start_sel == 2) first_start = start_owed || ($urandom_range(0, 3) != 0);
    else first_start = (start_sel == 1);
    start_owed = 1'b0;
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 12))
        byte_queue.insert(byte_queue.size(), rx_item_t'{8'($urandom), 1'($urandom), 1'b0});
      start_owed = 1'b1;
      return;
    end
    body.insert(body.size(),
                (flaw == FLAW_ID) ? (set_slave ^ 8'($urandom_range(1, 255))) : set_slave);
    if (flaw == FLAW_EXCEPT) begin
      fn = FuncExcept;
    end else if (flaw == FLAW_FUNC) begin
      fn = $urandom_range(0, 1) ? (set_ack ? FuncRead : FuncWrite) : 8'($urandom);
      while (fn == FuncExcept || fn == (set_ack ? FuncWrite : FuncRead)) fn = 8'($urandom);
    end else begin
      fn = set_ack ? FuncWrite : FuncRead;
    end
    body.insert(body.size(), fn);
    if (set_ack) begin
      addr = set_addr;
      value = set_value;
      if (flaw == FLAW_ECHO) begin
        if ($urandom_range(0, 1)) addr ^= 16'($urandom_range(1, 65535));
        else value ^= 16'($urandom_range(1, 65535));
      end
      body.insert(body.size(), addr[15:8]);
      body.insert(body.size(), addr[7:0]);
      body.insert(body.size(), value[15:8]);
      body.insert(body.size(), value[7:0]);
    end else begin
      body.insert(body.size(), 8'(2 * regs) ^
                  ((flaw == FLAW_COUNT) ? 8'($urandom_range(1, 255)) : 8'h00));
      repeat (2 * regs) body.insert(body.size(), (fill < 0) ? 8'($urandom) : 8'(fill));
    end
    crc = CrcInit;
    foreach (body[i]) crc = crc16_step(crc, body[i]);
    body.insert(body.size(), crc[7:0]);
    body.insert(body.size(), crc[15:8]);
    if (flaw == FLAW_CRC) begin
      k = $urandom_range(0, body.size() - 1);
      body[k] ^= 8'($urandom_range(1, 255));
    end
    if (flaw == FLAW_SHORT) begin
      cut = $urandom_range(1, body.size() - 1);
      body = body[0:cut-1];
      start_owed = 1'b1;
    end
    foreach (body[i])
      byte_queue.insert(byte_queue.size(),
                        rx_item_t'{body[i], (i == 0) ? first_start : 1'b0,
                                   (i == 0) ? hold : 1'b0});
  endtask

  task automatic fill_random(input int budget);
    int base;
    base = byte_queue.size();
    while (byte_queue.size() - base < budget)
      queue_frame(pick_flaw(), -1, 2, $urandom_range(0, 24) == 0);
  endtask

  // Waits until every byte is taken and every result has arrived, then lets
  // the pipeline drain bytes that produce no result.
  task automatic settle();
    do @(negedge clk); while (byte_queue.size() != 0 || in_valid);
    @(negedge clk);
    while (!drained) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgSlaveId:   set_slave = val[7:0];
      CfgAckMode:   set_ack = val[0];
      CfgRegCount:  set_count = val[6:0];
      CfgEchoAddr:  set_addr = val;
      CfgEchoValue: set_value = val;
      default: ;
    endcase
  endtask

  // Unused upper data bits are random so that masking is exercised.
  task automatic run_phase(input logic [7:0] slave, input logic ack, input logic [6:0] regs,
                           input logic [15:0] addr, input logic [15:0] value,
                           input int budget);
    write_reg(CfgSlaveId, {8'($urandom), slave});
    write_reg(CfgAckMode, {15'($urandom), ack});
    write_reg(CfgRegCount, {9'($urandom), regs});
    write_reg(CfgEchoAddr, addr);
    write_reg(CfgEchoValue, value);
    @(negedge clk);
    start_owed = 1'b1;
    fill_random(budget);
    settle();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Reset register values: all-ones data, all-zero data with no restart
    // flag after a complete frame, a dropped partial frame, a frame of random
    // data, then a frame held back until the earlier results are all out.
    queue_frame(FLAW_NONE, 8'hFF, 1, 1'b0);
    queue_frame(FLAW_NONE, 8'h00, 0, 1'b0);
    queue_frame(FLAW_SHORT, -1, 1, 1'b0);
    queue_frame(FLAW_NONE, -1, 1, 1'b0);
    queue_frame(FLAW_NONE, -1, 2, 1'b1);
    fill_random(100);
    settle();
    // Zero registers gives a five-byte frame with no data words.
    run_phase(8'h00, 1'b0, 7'd0, 16'hFFFF, 16'hFFFF, 80);
    run_phase(8'hFF, 1'b1, 7'd127, 16'hFFFF, 16'hFFFF, 100);
    run_phase(8'h5A, 1'b1, 7'd1, 16'h0000, 16'h0000, 80);
    run_phase(8'($urandom), 1'b0, 7'($urandom_range(2, 6)), 16'($urandom),
              16'($urandom), 100);
    run_phase(8'($urandom), 1'b0, MaxRegisters, 16'($urandom), 16'($urandom), 1);
    // A count above the maximum saturates.
    run_phase(8'($urandom), 1'b0, 7'd127, 16'($urandom), 16'($urandom), 1);
    run_phase(8'($urandom), 1'b1, 7'($urandom), 16'($urandom), 16'($urandom), 100);
    run_phase(8'($urandom), 1'b0, 7'($urandom_range(1, 3)), 16'($urandom),
              16'($urandom), 80);
    if (expected_replies.size() != 0) begin
      report_failure("missing result", expected_replies[0], '0);
      errors += expected_replies.size() - 1;
    end
    if (errors == 0) begin
      $display("modbus_rtu_response_checker_top verification clean");
    end else begin
      $display("modbus_rtu_response_checker_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("modbus_rtu_response_checker_top verification failed");
    $finish;
  end

endmodule
